@@ hdl/inode_block_store_assert.svh @@
// Assertion macros for the checker file ibs_chk.
`ifndef INODE_BLOCK_STORE_ASSERT_SVH
`define INODE_BLOCK_STORE_ASSERT_SVH

// Clocked assertion, quiet while reset is asserted.
`define IBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define IBS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/ibs_pkg.sv @@
// ----------------------------------------------------------------------------
// ibs_pkg
// Types and constants of the inode block store: beat payloads, command and
// status codes, and the control bundles between the sequencer and its units.
// ----------------------------------------------------------------------------
package ibs_pkg;

  localparam int FILE_SLOTS      = 16;
  localparam int NUM_BLOCKS      = 64;
  localparam int BLOCK_BYTES     = 16;
  localparam int BLOCKS_PER_FILE = 8;

  localparam int SLOT_W   = 4;
  localparam int BLK_W    = 6;
  localparam int OFF_W    = 4;
  localparam int BPF_W    = 3;
  localparam int ENTRY_W  = SLOT_W + BPF_W;
  localparam int DISK_AW  = BLK_W + OFF_W;
  localparam int FREE_W   = 7;
  localparam int NEED_W   = 5;

  localparam logic [1:0] CMD_OPEN = 2'd0;
  localparam logic [1:0] CMD_DATA = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SLOT   = 3'd1;
  localparam logic [2:0] ST_DISK_FULL = 3'd2;
  localparam logic [2:0] ST_BAD_SLOT  = 3'd3;
  localparam logic [2:0] ST_PAST_SIZE = 3'd4;
  localparam logic [2:0] ST_NO_WRITE  = 3'd5;
  localparam logic [2:0] ST_BUSY      = 3'd6;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] file_slot;
    logic [6:0] byte_offset;
    logic [7:0] file_size;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot_out;
    logic [7:0] read_byte;
  } out_t;

  // bitmap and free-count updates
  typedef struct packed {
    logic              claim_slot;
    logic [SLOT_W-1:0] slot_idx;
    logic              reserve;
    logic [NEED_W-1:0] need;
    logic              claim_blk;
    logic [BLK_W-1:0]  blk_idx;
  } alloc_ctl_t;

  // memory port requests
  typedef struct packed {
    logic               size_we;
    logic [SLOT_W-1:0]  size_waddr;
    logic [7:0]         size_wdata;
    logic [SLOT_W-1:0]  size_raddr;
    logic               list_we;
    logic [ENTRY_W-1:0] list_waddr;
    logic [BLK_W-1:0]   list_wdata;
    logic [ENTRY_W-1:0] list_raddr;
    logic               disk_we;
    logic [DISK_AW-1:0] disk_waddr;
    logic [7:0]         disk_wdata;
    logic [DISK_AW-1:0] disk_raddr;
  } store_req_t;

endpackage

@@ hdl/ibs_alloc.sv @@
// ----------------------------------------------------------------------------
// ibs_alloc
// Slot and block bitmaps, free-block count and lowest-free searches.
// ----------------------------------------------------------------------------
module ibs_alloc (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ibs_pkg::alloc_ctl_t               ctl,
  output logic [ibs_pkg::FILE_SLOTS-1:0]    slot_used,
  output logic                              free_slot_ok,
  output logic [ibs_pkg::SLOT_W-1:0]        free_slot_idx,
  output logic                              free_blk_ok,
  output logic [ibs_pkg::BLK_W-1:0]         free_blk_idx,
  output logic [ibs_pkg::FREE_W-1:0]        free_blocks
);

  logic [ibs_pkg::FILE_SLOTS-1:0]  slot_used_r;
  logic [ibs_pkg::NUM_BLOCKS-1:0]  blk_used_r;
  logic [ibs_pkg::FREE_W-1:0]      free_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_used_r <= '0;
      blk_used_r  <= '0;
      free_r      <= ibs_pkg::FREE_W'(ibs_pkg::NUM_BLOCKS);
    end else begin
      if (ctl.claim_slot) slot_used_r[ctl.slot_idx] <= 1'b1;
      if (ctl.claim_blk)  blk_used_r[ctl.blk_idx]   <= 1'b1;
      if (ctl.reserve)    free_r <= free_r - {2'b00, ctl.need};
    end
  end

  // lowest index wins: scan downward, last hit stays
  always_comb begin
    free_slot_ok  = 1'b0;
    free_slot_idx = '0;
    for (int i = ibs_pkg::FILE_SLOTS - 1; i >= 0; i--) begin
      if (!slot_used_r[i]) begin
        free_slot_ok  = 1'b1;
        free_slot_idx = ibs_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    free_blk_ok  = 1'b0;
    free_blk_idx = '0;
    for (int i = ibs_pkg::NUM_BLOCKS - 1; i >= 0; i--) begin
      if (!blk_used_r[i]) begin
        free_blk_ok  = 1'b1;
        free_blk_idx = ibs_pkg::BLK_W'(i);
      end
    end
  end

  assign slot_used   = slot_used_r;
  assign free_blocks = free_r;

endmodule

@@ hdl/ibs_store.sv @@
// ----------------------------------------------------------------------------
// ibs_store
// Slot size table, per-slot block lists and the byte disk. Synchronous
// memories, one write and one registered read each.
// ----------------------------------------------------------------------------
module ibs_store (
  input  logic                       clk,
  input  ibs_pkg::store_req_t        req,
  output logic [7:0]                 size_q,
  output logic [ibs_pkg::BLK_W-1:0]  list_q,
  output logic [7:0]                 disk_q
);

  logic [7:0]                size_mem [ibs_pkg::FILE_SLOTS];
  logic [ibs_pkg::BLK_W-1:0] list_mem [ibs_pkg::FILE_SLOTS * ibs_pkg::BLOCKS_PER_FILE];
  logic [7:0]                disk_mem [ibs_pkg::NUM_BLOCKS * ibs_pkg::BLOCK_BYTES];

  always_ff @(posedge clk) begin
    if (req.size_we) size_mem[req.size_waddr] <= req.size_wdata;
    size_q <= size_mem[req.size_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.list_we) list_mem[req.list_waddr] <= req.list_wdata;
    list_q <= list_mem[req.list_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.disk_we) disk_mem[req.disk_waddr] <= req.disk_wdata;
    disk_q <= disk_mem[req.disk_raddr];
  end

endmodule

@@ hdl/inode_block_store.sv @@
// ----------------------------------------------------------------------------
// inode_block_store
// Block store with slot and block bitmaps, per-slot block lists and a disk.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one command beat: open (file size),
// data (next content byte of the open file) or read (slot, offset). Every
// beat yields exactly one result beat on out_valid/out_ready with status,
// slot and read byte.
// One beat is processed at a time: accept, memory lookup, execute, (disk read
// for a read command that passes its checks), then load of the output
// register. Only such a read takes the disk-read step, since its block list
// entry and then its disk byte come from a chain of synchronous memory reads.
// in_ready rises in the same cycle as out_valid, so a new beat may be taken
// while the previous result still waits on out_ready. A new beat is taken
// only after the previous result has been loaded into the output register.
// If the output register is still full when a result is ready, the sequencer
// holds that result until out_ready frees the register.
// Reset (synchronous, rst_n low) frees all slots and blocks, restores the
// free-block count and ends any open write; memory contents are not cleared.
// ----------------------------------------------------------------------------
module inode_block_store (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ibs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ibs_pkg::out_t out_data
);

  typedef enum logic [2:0] {S_IDLE, S_LOOK, S_EXEC, S_DISK, S_OUT} state_t;

  state_t         state_r, state_nxt;
  ibs_pkg::in_t   item_r, item_nxt;
  ibs_pkg::out_t  res_r, res_nxt;
  ibs_pkg::out_t  out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           writing_r, writing_nxt;
  logic [3:0]     wr_slot_r, wr_slot_nxt;
  logic [7:0]     wr_pos_r, wr_pos_nxt;
  logic [7:0]     wr_size_r, wr_size_nxt;

  ibs_pkg::alloc_ctl_t               actl;
  ibs_pkg::store_req_t               sreq;
  logic [ibs_pkg::FILE_SLOTS-1:0]    slot_used;
  logic                              free_slot_ok, free_blk_ok;
  logic [ibs_pkg::SLOT_W-1:0]        free_slot_idx;
  logic [ibs_pkg::BLK_W-1:0]         free_blk_idx;
  logic [ibs_pkg::FREE_W-1:0]        free_blocks;
  logic [7:0]                        size_q, disk_q;
  logic [ibs_pkg::BLK_W-1:0]         list_q;

  logic [8:0]                        need_sum;
  logic [ibs_pkg::NEED_W-1:0]        need;
  logic [ibs_pkg::OFF_W-1:0]         blk_off;
  logic [ibs_pkg::BLK_W-1:0]         data_blk;
  logic [7:0]                        pos_inc;

  ibs_alloc u_alloc (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (actl),
    .slot_used     (slot_used),
    .free_slot_ok  (free_slot_ok),
    .free_slot_idx (free_slot_idx),
    .free_blk_ok   (free_blk_ok),
    .free_blk_idx  (free_blk_idx),
    .free_blocks   (free_blocks)
  );

  ibs_store u_store (
    .clk    (clk),
    .req    (sreq),
    .size_q (size_q),
    .list_q (list_q),
    .disk_q (disk_q)
  );

  assign need_sum = {1'b0, item_r.file_size} + 9'(ibs_pkg::BLOCK_BYTES - 1);
  assign need     = need_sum[8:4];
  assign blk_off  = wr_pos_r[3:0];
  assign pos_inc  = wr_pos_r + 8'd1;
  assign data_blk = (blk_off == '0) ? free_blk_idx : list_q;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    writing_nxt   = writing_r;
    wr_slot_nxt   = wr_slot_r;
    wr_pos_nxt    = wr_pos_r;
    wr_size_nxt   = wr_size_r;
    actl          = '0;

    sreq            = '0;
    sreq.size_raddr = item_r.file_slot;
    sreq.list_raddr = (item_r.command == ibs_pkg::CMD_DATA) ?
                      {wr_slot_r, wr_pos_r[6:4]} :
                      {item_r.file_slot, item_r.byte_offset[6:4]};
    sreq.disk_raddr = {list_q, item_r.byte_offset[3:0]};

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: state_nxt = S_EXEC;
      S_EXEC: begin
        res_nxt   = '0;
        state_nxt = S_OUT;
        case (item_r.command)
          ibs_pkg::CMD_OPEN: begin
            if (writing_r) begin
              res_nxt.status = ibs_pkg::ST_BUSY;
            end else if (!free_slot_ok) begin
              res_nxt.status = ibs_pkg::ST_NO_SLOT;
            end else if (need > ibs_pkg::NEED_W'(ibs_pkg::BLOCKS_PER_FILE) ||
                         {2'b00, need} > free_blocks) begin
              res_nxt.status = ibs_pkg::ST_DISK_FULL;
            end else begin
              actl.claim_slot = 1'b1;
              actl.slot_idx   = free_slot_idx;
              actl.reserve    = 1'b1;
              actl.need       = need;
              sreq.size_we    = 1'b1;
              sreq.size_waddr = free_slot_idx;
              sreq.size_wdata = item_r.file_size;
              wr_slot_nxt     = free_slot_idx;
              wr_pos_nxt      = '0;
              wr_size_nxt     = item_r.file_size;
              writing_nxt     = (item_r.file_size != 8'd0);
              res_nxt.status  = ibs_pkg::ST_OK;
              res_nxt.slot_out = free_slot_idx;
            end
          end
          ibs_pkg::CMD_DATA: begin
            if (!writing_r) begin
              res_nxt.status = ibs_pkg::ST_NO_WRITE;
            end else if (blk_off == '0 && !free_blk_ok) begin
              res_nxt.status = ibs_pkg::ST_DISK_FULL;
            end else begin
              if (blk_off == '0) begin
                actl.claim_blk  = 1'b1;
                actl.blk_idx    = free_blk_idx;
                sreq.list_we    = 1'b1;
                sreq.list_waddr = {wr_slot_r, wr_pos_r[6:4]};
                sreq.list_wdata = free_blk_idx;
              end
              sreq.disk_we    = 1'b1;
              sreq.disk_waddr = {data_blk, blk_off};
              sreq.disk_wdata = item_r.data_byte;
              wr_pos_nxt      = pos_inc;
              if (pos_inc >= wr_size_r) writing_nxt = 1'b0;
              res_nxt.status   = ibs_pkg::ST_OK;
              res_nxt.slot_out = wr_slot_r;
            end
          end
          ibs_pkg::CMD_READ: begin
            if (!slot_used[item_r.file_slot]) begin
              res_nxt.status   = ibs_pkg::ST_BAD_SLOT;
              res_nxt.slot_out = item_r.file_slot;
            end else if ({1'b0, item_r.byte_offset} >= size_q) begin
              res_nxt.status   = ibs_pkg::ST_PAST_SIZE;
              res_nxt.slot_out = item_r.file_slot;
            end else if (writing_r && wr_slot_r == item_r.file_slot &&
                         {1'b0, item_r.byte_offset} >= wr_pos_r) begin
              res_nxt.status = ibs_pkg::ST_BUSY;
            end else begin
              res_nxt.status   = ibs_pkg::ST_OK;
              res_nxt.slot_out = item_r.file_slot;
              state_nxt        = S_DISK;
            end
          end
          default: res_nxt = '0;
        endcase
      end
      S_DISK: begin
        res_nxt.read_byte = disk_q;
        state_nxt         = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      writing_r   <= 1'b0;
      wr_slot_r   <= '0;
      wr_pos_r    <= '0;
      wr_size_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      writing_r   <= writing_nxt;
      wr_slot_r   <= wr_slot_nxt;
      wr_pos_r    <= wr_pos_nxt;
      wr_size_r   <= wr_size_nxt;
    end
    item_r <= item_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ hdl/ibs_chk.sv @@
// ----------------------------------------------------------------------------
// ibs_chk
// Port-level checks on the inode block store, bound to the top level.
// ----------------------------------------------------------------------------
`include "inode_block_store_assert.svh"

module ibs_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input ibs_pkg::out_t out_data
);

  // stalled result beat holds
  `IBS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result beat changed while stalled")

  // one command in flight: no accept right after an accept
  `IBS_ASSERT(a_one_inflight, in_valid && in_ready |=> !in_ready, "input taken while a command is in flight")

  // errors never carry data
  `IBS_ASSERT(a_err_zero, out_valid && out_data.status != ibs_pkg::ST_OK |-> out_data.read_byte == 8'd0, "error beat with nonzero read byte")

  `IBS_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind inode_block_store ibs_chk u_ibs_chk (.*);
